>>> hdl/sspt_pkg.sv
// Package for the spaced seek point table.
// Holds the item types, result codes, controller states and the command
// and status groups between controller and datapath. No dependencies.
package sspt_pkg;

  // Default table depth and reset value of the spacing register.
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam logic [15:0] SPACING_RESET   = 16'd64;

  // Result codes.
  localparam logic [2:0] STAT_FOUND   = 3'd0;
  localparam logic [2:0] STAT_NONE    = 3'd1;
  localparam logic [2:0] STAT_STORED  = 3'd2;
  localparam logic [2:0] STAT_SKIPPED = 3'd3;
  localparam logic [2:0] STAT_DROPPED = 3'd4;

  // Operation codes.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] frame;
    logic [47:0] offset;
  } sspt_in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_frame;
    logic [47:0] found_offset;
  } sspt_out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_CHECK,
    S_CMP,
    S_EMIT
  } sspt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // latch the input item and open the search window
    logic add_exec;    // decide and perform an add, emit its result
    logic rd_mid;      // read the frame at the window midpoint
    logic cmp_step;    // narrow the window from the frame just read
    logic rd_found;    // read the point just below the window
    logic emit_found;  // emit the point that was read
    logic emit_none;   // emit a none-found result
  } sspt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_find;   // the offered item is a find
    logic search_open;  // the search window is not empty
    logic lo_zero;      // no stored point lies at or below the desired frame
  } sspt_stat_t;

endpackage

>>> hdl/spaced_seek_point_table.sv
// Spaced seek point table, top level; depends on sspt_pkg, sspt_ctrl, sspt_dp.
// Add: the item is latched, decided in S_ADD and its result registered. Find: binary
// search, each step a midpoint read in S_CHECK and a window update in S_CMP, at most
// floor(log2(points stored)) + 1 steps; then the point below is read and shown, or none.
// Busy drops in the cycle the result is shown; results cannot be stalled.
// Synchronous active-low reset: empty table, newest frame zero, spacing 64.
module spaced_seek_point_table
  import sspt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  sspt_in_item_t  in_item,
  output logic           out_valid,
  output sspt_out_item_t out_item,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_data
);

  sspt_cmd_t  cmd;
  sspt_stat_t stat;

  // The spacing register can be written in any cycle.
  assign cfg_ready = 1'b1;

  sspt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sspt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> hdl/sspt_ctrl.sv
// Controller of the spaced seek point table.
// Sequences adds and the binary search; depends on sspt_pkg.
module sspt_ctrl
  import sspt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  sspt_stat_t stat,
  output sspt_cmd_t  cmd,
  output logic       busy
);

  sspt_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = stat.in_is_find ? S_CHECK : S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_exec = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_CHECK: begin
        if (stat.search_open) begin
          cmd.rd_mid = 1'b1;
          state_nxt  = S_CMP;
        end else if (stat.lo_zero) begin
          cmd.emit_none = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.rd_found = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_EMIT: begin
        cmd.emit_found = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> hdl/sspt_dp.sv
// Datapath of the spaced seek point table.
// Holds the point memories, count, spacing register, search window and
// result register; depends on sspt_pkg.
module sspt_dp
  import sspt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sspt_in_item_t  in_item,
  input  logic           cfg_wr,
  input  logic [15:0]    cfg_data,
  input  sspt_cmd_t      cmd,
  output sspt_stat_t     stat,
  output logic           out_valid,
  output sspt_out_item_t out_item
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // Point memories.
  logic [31:0] frames_mem  [TABLE_DEPTH];
  logic [47:0] offsets_mem [TABLE_DEPTH];

  logic [15:0]    spacing_r;
  logic [CNT_W-1:0] count_r;
  logic [31:0]    newest_r;
  sspt_in_item_t  item_r;
  logic [CNT_W-1:0] lo_r, hi_r;
  logic [31:0]    frame_rd_r;
  logic [47:0]    off_rd_r;
  logic           out_valid_r;
  sspt_out_item_t out_item_r;

  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] below;
  logic [32:0]      limit;
  logic             too_close;
  logic             full;
  logic             store;

  // Search window midpoint and the index just below the window.
  assign mid   = lo_r + ((hi_r - lo_r) >> 1);
  assign below = lo_r - CNT_W'(1);

  // Add decision: spacing test first, then the full test.
  assign limit     = {1'b0, newest_r} + {17'b0, spacing_r};
  assign too_close = (count_r != '0) && (limit > {1'b0, item_r.frame});
  assign full      = (count_r == CNT_W'(TABLE_DEPTH));
  assign store     = cmd.add_exec && !too_close && !full;

  assign stat.in_is_find  = (in_item.operation == OP_FIND);
  assign stat.search_open = (lo_r < hi_r);
  assign stat.lo_zero     = (lo_r == '0);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SPACING_RESET;
    end else if (cfg_wr) begin
      spacing_r <= cfg_data;
    end
  end

  // Table fill state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      newest_r <= '0;
    end else if (store) begin
      count_r  <= count_r + CNT_W'(1);
      newest_r <= item_r.frame;
    end
  end

  // Latched item and search window.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      lo_r   <= '0;
      hi_r   <= count_r;
    end else if (cmd.cmp_step) begin
      if (frame_rd_r <= item_r.frame) begin
        lo_r <= mid + CNT_W'(1);
      end else begin
        hi_r <= mid;
      end
    end
  end

  // Frame memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (store) begin
      frames_mem[count_r[IDX_W-1:0]] <= item_r.frame;
    end
    if (cmd.rd_mid) begin
      frame_rd_r <= frames_mem[mid[IDX_W-1:0]];
    end else if (cmd.rd_found) begin
      frame_rd_r <= frames_mem[below[IDX_W-1:0]];
    end
  end

  // Offset memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (store) begin
      offsets_mem[count_r[IDX_W-1:0]] <= item_r.offset;
    end
    if (cmd.rd_found) begin
      off_rd_r <= offsets_mem[below[IDX_W-1:0]];
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.add_exec || cmd.emit_found || cmd.emit_none;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.add_exec) begin
      out_item_r.found_frame  <= '0;
      out_item_r.found_offset <= '0;
      if (too_close) begin
        out_item_r.status <= STAT_SKIPPED;
      end else if (full) begin
        out_item_r.status <= STAT_DROPPED;
      end else begin
        out_item_r.status <= STAT_STORED;
      end
    end else if (cmd.emit_found) begin
      out_item_r.status       <= STAT_FOUND;
      out_item_r.found_frame  <= frame_rd_r;
      out_item_r.found_offset <= off_rd_r;
    end else if (cmd.emit_none) begin
      out_item_r.status       <= STAT_NONE;
      out_item_r.found_frame  <= '0;
      out_item_r.found_offset <= '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> hdl/sspt_checker.sv
// Port-level checks for the spaced seek point table, with its bind.
// Depends on sspt_pkg and the top level spaced_seek_point_table.
module sspt_assertions
  import sspt_pkg::*;
(
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input sspt_out_item_t out_item
);

  // An accepted item always occupies the block for the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // A result is shown only once the block has finished with its item.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Each item gives one single-cycle result.
  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // Only a found result carries a point.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != STAT_FOUND) |->
      (out_item.found_frame == '0) && (out_item.found_offset == '0))
    else $error("non-found result carries nonzero fields");

endmodule

bind spaced_seek_point_table sspt_assertions u_sspt_assertions (.*);
